@@ rtl/ttr_pkg.sv @@
`timescale 1ns / 1ps

package ttr_pkg;

  // field widths
  localparam int CODE_W  = 40;
  localparam int AREA_W  = 32;
  localparam int PRICE_W = 32;
  localparam int PROD_W  = AREA_W + PRICE_W;
  localparam int RANK_W  = 2;

  // default depth of the ranking
  localparam int TOP_COUNT = 3;

  // one record
  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [AREA_W-1:0]  area;
    logic [PRICE_W-1:0] price;
  } rec_t;

  // a held or outgoing record with its valid bit
  typedef struct packed {
    rec_t rec;
    logic vld;
  } slot_t;

  // item traveling down the chain, one cell per cycle
  typedef struct packed {
    rec_t rec;
    logic vld;    // rec carries a record
    logic shift;  // an insertion happened above, cells below push down unconditionally
    logic fin;    // end of data set sweep
  } tok_t;

endpackage

@@ rtl/ttr_if.sv @@
`timescale 1ns / 1ps

// record input channel
interface ttr_in_if;
  logic                        valid;
  logic                        ready;
  logic [ttr_pkg::CODE_W-1:0]  code;
  logic [ttr_pkg::AREA_W-1:0]  area;
  logic [ttr_pkg::PRICE_W-1:0] price;
  logic                        final_record;

  modport source (output valid, code, area, price, final_record, input ready);
  modport sink   (input valid, code, area, price, final_record, output ready);
endinterface

// ranked result channel
interface ttr_out_if;
  logic                        valid;
  logic                        ready;
  logic [ttr_pkg::CODE_W-1:0]  out_code;
  logic [ttr_pkg::AREA_W-1:0]  out_area;
  logic [ttr_pkg::PRICE_W-1:0] out_price;
  logic [ttr_pkg::RANK_W-1:0]  rank;
  logic                        last_of_run;

  modport source (output valid, out_code, out_area, out_price, rank, last_of_run, input ready);
  modport sink   (input valid, out_code, out_area, out_price, rank, last_of_run, output ready);
endinterface

@@ rtl/ttr_cell.sv @@
`timescale 1ns / 1ps

module ttr_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  ttr_pkg::tok_t  tok_in,
  output ttr_pkg::tok_t  tok_out,
  input  logic           pop,
  input  ttr_pkg::slot_t up_in,
  output ttr_pkg::slot_t slot_out
);

  ttr_pkg::rec_t held_r;
  logic          held_vld_r;
  ttr_pkg::rec_t oslot_r;
  logic          oslot_vld_r;
  ttr_pkg::rec_t tok_rec_r;
  logic          tok_vld_r;
  logic          tok_shift_r;
  logic          tok_fin_r;

  logic [ttr_pkg::PROD_W-1:0] prod_new;
  logic [ttr_pkg::PROD_W-1:0] prod_held;
  logic                       beats;
  logic                       take;
  ttr_pkg::rec_t              held_new;
  logic                       held_new_vld;
  ttr_pkg::rec_t              pass_rec;
  logic                       pass_vld;
  logic                       pass_shift;

  // cross multiplied ratio compare, incoming strictly better than held
  assign prod_new  = tok_in.rec.price * held_r.area;
  assign prod_held = held_r.price * tok_in.rec.area;
  assign beats     = prod_new > prod_held;

  // insertion decision
  assign take = tok_in.vld & (~held_vld_r | tok_in.shift | beats);

  always_comb begin
    held_new     = held_r;
    held_new_vld = held_vld_r;
    pass_rec     = tok_in.rec;
    pass_vld     = 1'b0;
    pass_shift   = 1'b0;
    if (take) begin
      held_new     = tok_in.rec;
      held_new_vld = 1'b1;
      if (held_vld_r) begin
        pass_rec   = held_r;
        pass_vld   = 1'b1;
        pass_shift = 1'b1;
      end
    end else if (tok_in.vld) begin
      pass_vld = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_vld_r  <= 1'b0;
      oslot_vld_r <= 1'b0;
      tok_vld_r   <= 1'b0;
      tok_shift_r <= 1'b0;
      tok_fin_r   <= 1'b0;
    end else begin
      held_vld_r  <= held_new_vld & ~tok_in.fin;
      tok_vld_r   <= pass_vld;
      tok_shift_r <= pass_shift;
      tok_fin_r   <= tok_in.fin;
      if (tok_in.fin) begin
        oslot_vld_r <= held_new_vld;
      end else if (pop) begin
        oslot_vld_r <= up_in.vld;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    held_r    <= held_new;
    tok_rec_r <= pass_rec;
    if (tok_in.fin) begin
      oslot_r <= held_new;
    end else if (pop) begin
      oslot_r <= up_in.rec;
    end
  end

  assign tok_out  = {tok_rec_r, tok_vld_r, tok_shift_r, tok_fin_r};
  assign slot_out = {oslot_r, oslot_vld_r};

endmodule

@@ rtl/top_three_by_ratio_unit.sv @@
`timescale 1ns / 1ps

// Keeps the TOP_COUNT records with the highest price per unit area (ratios compared
// by cross multiplication, ties keep the earlier record, zero area ranks above any
// nonzero area) and, when a record flagged final_record arrives, emits the held
// records best first with rank and last_of_run, then starts a fresh data set.
// Records are taken one per cycle: each enters a row of TOP_COUNT cells and moves
// one cell per cycle, so the next record can follow right behind it. A final record
// sweeps the row and copies each cell into an output row; the first result is
// valid once the sweep has left the row and started emission, then one result per
// cycle while out_s.ready is high. Non-final records of the next data set are taken
// meanwhile; a further final record waits until the previous results are all taken.

module top_three_by_ratio_unit #(
  parameter int TOP_COUNT = ttr_pkg::TOP_COUNT
) (
  input logic       clk,
  input logic       rst_n,
  ttr_in_if.sink    in_s,
  ttr_out_if.source out_s
);

  localparam int CNT_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

  ttr_pkg::tok_t  tok   [TOP_COUNT+1];
  ttr_pkg::slot_t oslot [TOP_COUNT+1];
  logic [TOP_COUNT:0] fin_vec;

  ttr_pkg::rec_t    in_rec_r;
  logic             in_vld_r;
  logic             in_fin_r;
  logic             emit_r;
  logic [CNT_W-1:0] rank_r;

  logic in_acc;
  logic fin_busy;
  logic pop;
  logic pop_last;

  // input register feeding the head of the chain
  assign fin_busy   = (|fin_vec) | emit_r;
  assign in_s.ready = ~(in_s.final_record & fin_busy);
  assign in_acc     = in_s.valid & in_s.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      in_fin_r <= 1'b0;
    end else begin
      in_vld_r <= in_acc;
      in_fin_r <= in_acc & in_s.final_record;
    end
  end

  always_ff @(posedge clk) begin
    in_rec_r <= {in_s.code, in_s.area, in_s.price};
  end

  assign tok[0] = {in_rec_r, in_vld_r, 1'b0, in_fin_r};

  // row of ranking cells, best first
  assign oslot[TOP_COUNT] = '0;

  for (genvar i = 0; i < TOP_COUNT; i++) begin : g_cell
    ttr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1]),
      .pop      (pop),
      .up_in    (oslot[i+1]),
      .slot_out (oslot[i])
    );
  end

  for (genvar i = 0; i <= TOP_COUNT; i++) begin : g_fin
    assign fin_vec[i] = tok[i].fin;
  end

  // result emission from the output row
  assign pop      = out_s.valid & out_s.ready;
  assign pop_last = pop & ~oslot[1].vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r <= 1'b0;
      rank_r <= '0;
    end else begin
      if (tok[TOP_COUNT].fin) begin
        emit_r <= 1'b1;
      end else if (pop_last) begin
        emit_r <= 1'b0;
      end
      if (pop_last) begin
        rank_r <= '0;
      end else if (pop) begin
        rank_r <= rank_r + CNT_W'(1);
      end
    end
  end

  assign out_s.valid       = emit_r & oslot[0].vld;
  assign out_s.out_code    = oslot[0].rec.code;
  assign out_s.out_area    = oslot[0].rec.area;
  assign out_s.out_price   = oslot[0].rec.price;
  assign out_s.rank        = ttr_pkg::RANK_W'(rank_r);
  assign out_s.last_of_run = ~oslot[1].vld;

`ifndef SYNTHESIS
  // at most one data set sweep in flight
  a_one_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(fin_vec) <= 1)
    else $error("more than one final sweep in the chain");

  // a completed sweep always leaves a best record to emit
  a_emit_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    emit_r |-> oslot[0].vld)
    else $error("emission active with empty head slot");

  // sweep leaving the chain starts emission
  a_sweep_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
    tok[TOP_COUNT].fin |=> emit_r)
    else $error("sweep finished without starting emission");

  // emission never overlaps a sweep
  a_no_sweep_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit_r |-> !(|fin_vec[TOP_COUNT-1:0]))
    else $error("sweep in chain while emitting");

  // rank restarts after every run
  a_rank_restart: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(emit_r) |-> rank_r == '0)
    else $error("rank not cleared at end of run");
`endif

endmodule
